// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AAR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define AAR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define AAR_ASSERT(lbl, prop, msg)
`define AAR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== sv/aar_pkg.sv =====
// ---------------------------------------------------------------------------
// aar_pkg
// Types, constants and tables shared by the rotation matrix pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package aar_pkg;

	localparam int FRAC_BITS     = 14;
	localparam int CORDIC_STAGES = 16;
	localparam int ROOT_BITS     = 30;
	localparam int QUO_BITS      = 31;
	localparam int NUM_LANES     = 9;

	localparam int NORM_LAT   = 1 + ROOT_BITS;
	localparam int DIV_LAT    = QUO_BITS + 1;
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;
	localparam int ENTRY_LAT  = 4;
	localparam int ANG_DELAY  = NORM_LAT + DIV_LAT - CORDIC_LAT;
	localparam int PIPE_LAT   = NORM_LAT + DIV_LAT + ENTRY_LAT;

	typedef logic signed [35:0] ang_t;
	typedef logic signed [33:0] cs_t;
	typedef logic signed [31:0] unit_t;
	typedef logic signed [35:0] acc_t;
	typedef logic signed [15:0] smp_t;
	typedef logic [ROOT_BITS-1:0] root_t;
	typedef logic [60:0] wide_t;

	typedef struct packed {
		cs_t c;
		cs_t s;
		cs_t omc;
	} trig_t;

	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][15:0] mag;
	} axis_t;

	localparam ang_t Q30_PI      = 36'sd3373259426;
	localparam ang_t Q30_TWO_PI  = 36'sd6746518852;
	localparam ang_t Q30_HALF_PI = 36'sd1686629713;
	localparam cs_t  Q30_ONE     = 34'sd1073741824;
	localparam cs_t  CORDIC_GAIN = 34'sd652032874;

	localparam cs_t ATAN_Q30 [32] = '{
		34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
		34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
		34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
		34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
		34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
		34'sd1023,      34'sd511,       34'sd255,       34'sd127,
		34'sd63,        34'sd31,        34'sd15,        34'sd7,
		34'sd3,         34'sd1,         34'sd0,         34'sd0
	};

	localparam logic [1:0] OP_DIAG = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;

	localparam logic [1:0] LANE_I  [NUM_LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2};
	localparam logic [1:0] LANE_J  [NUM_LANES] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2};
	localparam logic [1:0] LANE_K  [NUM_LANES] = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0,
		2'd1, 2'd0, 2'd0};
	localparam logic [1:0] LANE_OP [NUM_LANES] = '{OP_DIAG, OP_SUB, OP_ADD, OP_ADD, OP_DIAG,
		OP_SUB, OP_SUB, OP_ADD, OP_DIAG};

	localparam acc_t OUT_HALF = acc_t'(1) <<< (29 - FRAC_BITS);
	localparam acc_t OUT_LIM  = acc_t'(1) <<< FRAC_BITS;
	localparam smp_t IDENT    = OUT_LIM[15:0];

	function automatic smp_t to_out(acc_t v);
		acc_t t;
		t = (v + OUT_HALF) >>> (30 - FRAC_BITS);
		if (t > OUT_LIM)
			t = OUT_LIM;
		if (t < -OUT_LIM)
			t = -OUT_LIM;
		return t[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/aar_cordic.sv =====
// ---------------------------------------------------------------------------
// aar_cordic
// Angle reduction and pipelined rotation-mode CORDIC giving cos, sin, 1-cos.
// ---------------------------------------------------------------------------
`default_nettype none
module aar_cordic (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [15:0]   angle,
	output aar_pkg::trig_t            trig
);

	localparam int N = aar_pkg::CORDIC_STAGES;

	aar_pkg::ang_t a0, a1, a2;
	logic          flip;

	aar_pkg::cs_t x_s [N+1];
	aar_pkg::cs_t y_s [N+1];
	aar_pkg::cs_t z_s [N+1];
	logic         f_s [N+1];

	aar_pkg::cs_t   c_n, s_n;
	aar_pkg::trig_t trig_q;

	always_comb begin
		a0 = aar_pkg::ang_t'(angle) <<< 18;
		if (a0 > aar_pkg::Q30_PI)
			a1 = a0 - aar_pkg::Q30_TWO_PI;
		else if (a0 < -aar_pkg::Q30_PI)
			a1 = a0 + aar_pkg::Q30_TWO_PI;
		else
			a1 = a0;
		flip = 1'b1;
		if (a1 > aar_pkg::Q30_HALF_PI)
			a2 = a1 - aar_pkg::Q30_PI;
		else if (a1 < -aar_pkg::Q30_HALF_PI)
			a2 = a1 + aar_pkg::Q30_PI;
		else begin
			a2 = a1;
			flip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= aar_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= a2[33:0];
			f_s[0] <= flip;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[g+1] <= f_s[g];
				if (z_s[g] >= 0) begin
					x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] - aar_pkg::ATAN_Q30[g];
				end else begin
					x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] + aar_pkg::ATAN_Q30[g];
				end
			end
		end
	end

	assign c_n = f_s[N] ? -x_s[N] : x_s[N];
	assign s_n = f_s[N] ? -y_s[N] : y_s[N];

	always_ff @(posedge clk) begin
		if (en) begin
			trig_q.c   <= c_n;
			trig_q.s   <= s_n;
			trig_q.omc <= aar_pkg::Q30_ONE - c_n;
		end
	end

	assign trig = trig_q;

endmodule
`default_nettype wire

// ===== sv/aar_isqrt.sv =====
// ---------------------------------------------------------------------------
// aar_isqrt
// Squared axis length and a one-bit-per-stage integer square root.
// ---------------------------------------------------------------------------
`default_nettype none
module aar_isqrt (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [15:0]   axis_x,
	input  wire logic signed [15:0]   axis_y,
	input  wire logic signed [15:0]   axis_z,
	output aar_pkg::root_t            root,
	output aar_pkg::axis_t            axis
);

	localparam int N = aar_pkg::ROOT_BITS;

	logic signed [31:0] sq_x, sq_y, sq_z;
	logic [31:0]        n2;
	aar_pkg::axis_t     ax_n;

	aar_pkg::wide_t rem_s  [N+1];
	aar_pkg::root_t root_s [N+1];
	aar_pkg::axis_t axis_s [N+1];

	always_comb begin
		sq_x = 32'(axis_x) * 32'(axis_x);
		sq_y = 32'(axis_y) * 32'(axis_y);
		sq_z = 32'(axis_z) * 32'(axis_z);
		n2   = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);
		ax_n.neg    = {axis_z[15], axis_y[15], axis_x[15]};
		ax_n.mag[0] = axis_x[15] ? 16'(-axis_x) : axis_x;
		ax_n.mag[1] = axis_y[15] ? 16'(-axis_y) : axis_y;
		ax_n.mag[2] = axis_z[15] ? 16'(-axis_z) : axis_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {1'b0, n2, 28'd0};
			root_s[0] <= '0;
			axis_s[0] <= ax_n;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int K = N - 1 - g;
		aar_pkg::wide_t cand;
		assign cand = (aar_pkg::wide_t'(root_s[g]) << (K + 1)) + (aar_pkg::wide_t'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				axis_s[g+1] <= axis_s[g];
				if (rem_s[g] >= cand) begin
					rem_s[g+1]  <= rem_s[g] - cand;
					root_s[g+1] <= root_s[g] | (aar_pkg::root_t'(1) << K);
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
	end

	assign root = root_s[N];
	assign axis = axis_s[N];

endmodule
`default_nettype wire

// ===== sv/aar_div_lane.sv =====
// ---------------------------------------------------------------------------
// aar_div_lane
// Restoring divider, one quotient bit per stage: unit axis component in Q30.
// ---------------------------------------------------------------------------
`default_nettype none
module aar_div_lane (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [15:0]    mag,
	input  wire logic           neg,
	input  wire aar_pkg::root_t root,
	output aar_pkg::unit_t      u
);

	localparam int N = aar_pkg::QUO_BITS;

	aar_pkg::wide_t rem_s [N+1];
	aar_pkg::root_t div_s [N+1];
	logic [N-1:0]   quo_s [N+1];
	logic           neg_s [N+1];
	aar_pkg::unit_t u_q;

	assign rem_s[0] = {1'b0, mag, 44'd0};
	assign div_s[0] = root;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int K = N - 1 - g;
		aar_pkg::wide_t trial;
		assign trial = aar_pkg::wide_t'(div_s[g]) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g+1] <= div_s[g];
				neg_s[g+1] <= neg_s[g];
				if (rem_s[g] >= trial) begin
					rem_s[g+1] <= rem_s[g] - trial;
					quo_s[g+1] <= quo_s[g] | (N'(1) << K);
				end else begin
					rem_s[g+1] <= rem_s[g];
					quo_s[g+1] <= quo_s[g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			u_q <= neg_s[N] ? -aar_pkg::unit_t'(quo_s[N]) : aar_pkg::unit_t'(quo_s[N]);
	end

	assign u = u_q;

endmodule
`default_nettype wire

// ===== sv/aar_entry_lane.sv =====
// ---------------------------------------------------------------------------
// aar_entry_lane
// One matrix entry: c*[diag] + (ui*uj)*(1-c) +/- s*uk, Q30 products.
// ---------------------------------------------------------------------------
`default_nettype none
module aar_entry_lane (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [1:0]     op,
	input  wire aar_pkg::unit_t ui,
	input  wire aar_pkg::unit_t uj,
	input  wire aar_pkg::unit_t uk,
	input  wire aar_pkg::trig_t trig,
	output aar_pkg::acc_t       m
);

	localparam logic signed [67:0] HALF = 68'sd1 <<< 29;

	logic signed [63:0] pij_s1;
	logic signed [65:0] psk_s1;
	aar_pkg::cs_t       omc_s1, c_s1, omc_s2, c_s2, c_s3;
	aar_pkg::cs_t       qij_s2;
	aar_pkg::acc_t      qsk_s2, qsk_s3;
	logic signed [67:0] pp_s3;
	logic signed [67:0] rij, rsk, rpp;
	aar_pkg::acc_t      m_s4, base, term;

	always_ff @(posedge clk) begin
		if (en) begin
			pij_s1 <= 64'(ui) * 64'(uj);
			psk_s1 <= 66'(trig.s) * 66'(uk);
			omc_s1 <= trig.omc;
			c_s1   <= trig.c;
		end
	end

	assign rij = (68'(pij_s1) + HALF) >>> 30;
	assign rsk = (68'(psk_s1) + HALF) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			qij_s2 <= rij[33:0];
			qsk_s2 <= rsk[35:0];
			omc_s2 <= omc_s1;
			c_s2   <= c_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s3  <= 68'(qij_s2) * 68'(omc_s2);
			qsk_s3 <= qsk_s2;
			c_s3   <= c_s2;
		end
	end

	assign rpp  = (pp_s3 + HALF) >>> 30;
	assign base = aar_pkg::acc_t'(rpp[35:0]);

	always_comb begin
		case (op)
			aar_pkg::OP_DIAG: term = aar_pkg::acc_t'(c_s3);
			aar_pkg::OP_ADD:  term = qsk_s3;
			aar_pkg::OP_SUB:  term = -qsk_s3;
			default:          term = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			m_s4 <= base + term;
	end

	assign m = m_s4;

endmodule
`default_nettype wire

// ===== sv/axis_angle_rotation_matrix_top.sv =====
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_top
// Rodrigues rotation matrix from angle (Q3.12) and unnormalised axis (Q1.14).
// ---------------------------------------------------------------------------
// Takes one beat per clock while the output buffer has room and returns
// the nine Q1.14 entries row-major through 67 pipeline stages plus the
// output register. Latency is set by the 31-stage square root (length of
// the axis) followed by three parallel 32-stage divider lanes; the CORDIC
// runs alongside on a delayed angle and nine entry lanes merge into the
// output register. A two-entry output buffer lets the pipeline take beats
// while a result waits. An all-zero axis returns the identity, m_tuser set.
`default_nettype none
`include "assert_macros.svh"
module axis_angle_rotation_matrix_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [63:0]    s_tdata,   // angle, axis_x, axis_y, axis_z
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [143:0]        m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic                m_tuser    // zero_axis
);

	localparam int L  = aar_pkg::PIPE_LAT;
	localparam int AD = aar_pkg::ANG_DELAY;
	localparam int NL = aar_pkg::NUM_LANES;

	logic en, acc, zero_in;

	logic        vld_q  [L];
	logic        zero_q [L];
	logic [15:0] ang_q  [AD];

	aar_pkg::trig_t trig;
	aar_pkg::root_t root;
	aar_pkg::axis_t axis;
	aar_pkg::unit_t u [3];
	aar_pkg::acc_t  m [NL];

	logic [143:0] new_data;
	logic         new_valid;
	logic [143:0] out_data_q, sk_data_q;
	logic         out_zero_q, sk_zero_q;
	logic         out_valid_q, sk_valid_q;

	assign en       = !sk_valid_q;
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign zero_in  = (s_tdata[63:16] == 48'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++)
				vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= acc;
			for (int i = 1; i < L; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= zero_in;
			for (int i = 1; i < L; i++)
				zero_q[i] <= zero_q[i-1];
			ang_q[0] <= s_tdata[15:0];
			for (int i = 1; i < AD; i++)
				ang_q[i] <= ang_q[i-1];
		end
	end

	aar_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (ang_q[AD-1]),
		.trig  (trig)
	);

	aar_isqrt u_isqrt (
		.clk    (clk),
		.en     (en),
		.axis_x (s_tdata[31:16]),
		.axis_y (s_tdata[47:32]),
		.axis_z (s_tdata[63:48]),
		.root   (root),
		.axis   (axis)
	);

	for (genvar g = 0; g < 3; g++) begin : g_div
		aar_div_lane u_div (
			.clk  (clk),
			.en   (en),
			.mag  (axis.mag[g]),
			.neg  (axis.neg[g]),
			.root (root),
			.u    (u[g])
		);
	end

	for (genvar g = 0; g < NL; g++) begin : g_entry
		aar_entry_lane u_entry (
			.clk  (clk),
			.en   (en),
			.op   (aar_pkg::LANE_OP[g]),
			.ui   (u[aar_pkg::LANE_I[g]]),
			.uj   (u[aar_pkg::LANE_J[g]]),
			.uk   (u[aar_pkg::LANE_K[g]]),
			.trig (trig),
			.m    (m[g])
		);
	end

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			if (zero_q[L-1])
				new_data[16*i +: 16] = (aar_pkg::LANE_OP[i] == aar_pkg::OP_DIAG) ?
					aar_pkg::IDENT : 16'd0;
			else
				new_data[16*i +: 16] = aar_pkg::to_out(m[i]);
		end
	end

	assign new_valid = vld_q[L-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				out_valid_q <= new_valid;
			end
		end else if (new_valid) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_valid_q) begin
			if (sk_valid_q) begin
				out_data_q <= sk_data_q;
				out_zero_q <= sk_zero_q;
			end else begin
				out_data_q <= new_data;
				out_zero_q <= zero_q[L-1];
			end
		end else if (new_valid) begin
			sk_data_q <= new_data;
			sk_zero_q <= zero_q[L-1];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_zero_q;

	`AAR_ASSERT(a_skid_behind_out, !sk_valid_q || out_valid_q, "buffer holds a beat with empty output")
	`AAR_ASSERT(a_skid_fill, !$rose(sk_valid_q) || $past(out_valid_q && !m_tready), "buffer filled while output free")
	`AAR_ASSERT(a_zero_ident, !(m_tvalid && m_tuser) || (m_tdata[15:0] == aar_pkg::IDENT && m_tdata[31:16] == 16'd0), "zero axis without identity")
	`AAR_ASSERT(a_sat, !m_tvalid || ($signed(m_tdata[15:0]) <= $signed(aar_pkg::IDENT) && $signed(m_tdata[15:0]) >= -$signed(aar_pkg::IDENT)), "entry beyond unit range")
	`AAR_ASSERT_NEXT(a_stall_hold, sk_valid_q && !m_tready, sk_valid_q, "buffered beat lost under stall")

endmodule
`default_nettype wire

// ===== sim/tb_axis_angle_rotation_matrix_top.sv =====
// ---------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix_top
// Self-checking bench for the axis-angle rotation matrix pipeline.
// ---------------------------------------------------------------------------
// A directed table (zero axis, unit axes, extreme angles and components)
// is followed by random beats. Every accepted input is run through a
// bit-exact fixed-point model (angle wrap, CORDIC, square root, divide,
// Rodrigues entries). Each output beat is compared with the oldest
// predicted matrix. Both sides are throttled in two phases, then run free
// in a third, with one long output hold-off for the pipeline to fill and back up.
`default_nettype none
module tb_axis_angle_rotation_matrix_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic        zero;
		logic [143:0] ent;
	} matrix_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [63:0] s_tdata;
	logic [143:0] m_tdata;

	axis_angle_rotation_matrix_top uut (.*);

	matrix_t matrix_q[$];
	int errors, n_sent, n_recv, n_zero, idle_cnt;
	int src_idle_pct, snk_idle_pct;
	bit hold_off, done_send;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint p, longint q);
		return shr(p * q + (64'sd1 << 29), 30);
	endfunction

	function automatic logic [15:0] round_entry(longint v);
		longint lim;
		lim = 64'sd1 << aar_pkg::FRAC_BITS;
		v = shr(v + (64'sd1 << (29 - aar_pkg::FRAC_BITS)), 30 - aar_pkg::FRAC_BITS);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v[15:0];
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned root, bit_;
		root = 0;
		bit_ = 64'd1 << 62;
		while (bit_ > n) bit_ >>= 2;
		while (bit_ != 0) begin
			if (n >= root + bit_) begin
				n -= root + bit_;
				root = (root >> 1) + bit_;
			end else begin
				root >>= 1;
			end
			bit_ >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic longint unit_of(longint a, longint r);
		longint unsigned mag;
		longint q;
		mag = (a < 0) ? -a : a;
		q = longint'((mag << 44) / longint'(r));
		return (a < 0) ? -q : q;
	endfunction

	function automatic matrix_t rotation_of(logic [63:0] d);
		matrix_t res;
		longint ang, u[3], ax[3], c, s, x, y, z, dx, dy, omc, r, m[9];
		longint unsigned n2;
		bit flip;
		flip = 0;
		ang = longint'($signed(d[15:0])) * 262144;
		for (int k = 0; k < 3; k++) ax[k] = longint'($signed(d[16*k+16 +: 16]));
		n2 = ax[0]*ax[0] + ax[1]*ax[1] + ax[2]*ax[2];
		res.zero = (n2 == 0);
		if (n2 == 0) begin
			res.ent = '0;
			for (int k = 0; k < 9; k += 4) res.ent[16*k +: 16] = round_entry(64'sd1 << 30);
			return res;
		end
		if (ang > aar_pkg::Q30_PI) ang -= aar_pkg::Q30_TWO_PI;
		else if (ang < -aar_pkg::Q30_PI) ang += aar_pkg::Q30_TWO_PI;
		if (ang > aar_pkg::Q30_HALF_PI) begin
			ang -= aar_pkg::Q30_PI;
			flip = 1;
		end else if (ang < -aar_pkg::Q30_HALF_PI) begin
			ang += aar_pkg::Q30_PI;
			flip = 1;
		end
		x = aar_pkg::CORDIC_GAIN;
		y = 0;
		z = ang;
		for (int i = 0; i < aar_pkg::CORDIC_STAGES && i < 32; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= aar_pkg::ATAN_Q30[i];
			end else begin
				x += dx; y -= dy; z += aar_pkg::ATAN_Q30[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		omc = (64'sd1 << 30) - c;
		r = isqrt(n2 << 28);
		for (int k = 0; k < 3; k++) u[k] = unit_of(ax[k], r);
		m[0] = c + qmul(qmul(u[0], u[0]), omc);
		m[1] = qmul(qmul(u[0], u[1]), omc) - qmul(s, u[2]);
		m[2] = qmul(qmul(u[0], u[2]), omc) + qmul(s, u[1]);
		m[3] = qmul(qmul(u[1], u[0]), omc) + qmul(s, u[2]);
		m[4] = c + qmul(qmul(u[1], u[1]), omc);
		m[5] = qmul(qmul(u[1], u[2]), omc) - qmul(s, u[0]);
		m[6] = qmul(qmul(u[2], u[0]), omc) - qmul(s, u[1]);
		m[7] = qmul(qmul(u[2], u[1]), omc) + qmul(s, u[0]);
		m[8] = c + qmul(qmul(u[2], u[2]), omc);
		for (int k = 0; k < 9; k++) res.ent[16*k +: 16] = round_entry(m[k]);
		return res;
	endfunction

	// directed rows: angle, x, y, z; fixed result only for zero-axis rows
	typedef struct {
		logic [15:0] ang, ax, ay, az;
		bit          fixed;
	} row_t;

	localparam logic [143:0] IDENT_M = {aar_pkg::IDENT, 16'h0, 16'h0, 16'h0, aar_pkg::IDENT,
		16'h0, 16'h0, 16'h0, aar_pkg::IDENT};

	row_t dir_tab[$] = '{
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1},
		'{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1},
		'{16'h8000, 16'h0000, 16'h0000, 16'h0000, 1},
		'{16'h0000, 16'h4000, 16'h0000, 16'h0000, 0},
		'{16'h1922, 16'h4000, 16'h0000, 16'h0000, 0},
		'{16'h1922, 16'h0000, 16'h4000, 16'h0000, 0},
		'{16'h1922, 16'h0000, 16'h0000, 16'h4000, 0},
		'{16'h3244, 16'h0000, 16'h0000, 16'h4000, 0},
		'{16'hcdbc, 16'h0000, 16'h0000, 16'h4000, 0},
		'{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0},
		'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 0},
		'{16'h7fff, 16'h8000, 16'h7fff, 16'h0001, 0},
		'{16'h8000, 16'h0001, 16'h0000, 16'h0000, 0},
		'{16'h0001, 16'h0000, 16'hffff, 16'h0000, 0},
		'{16'hffff, 16'h0000, 16'h0000, 16'h8000, 0},
		'{16'h1000, 16'h2d41, 16'h2d41, 16'h0000, 0},
		'{16'h4000, 16'h1234, 16'hedcb, 16'h5555, 0},
		'{16'hc000, 16'haaaa, 16'h5555, 16'hffff, 0},
		'{16'h5555, 16'h0000, 16'h0000, 16'h0000, 1},
		'{16'haaaa, 16'h7fff, 16'h0000, 16'h0000, 0}
	};

	task automatic send_beat(logic [63:0] d, bit fixed);
		matrix_t e;
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		e = rotation_of(d);
		if (fixed) begin
			e.zero = 1'b1;
			e.ent = IDENT_M;
		end
		matrix_q.push_back(e);
		n_sent++;
		if (d[63:16] == '0) n_zero++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] rnd_comp();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'($urandom_range(7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_random(int n);
		logic [63:0] d;
		for (int i = 0; i < n; i++) begin
			d = {rnd_comp(), rnd_comp(), rnd_comp(), 16'($urandom)};
			if ($urandom_range(19) == 0) d[63:16] = '0;
			send_beat(d, 0);
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		src_idle_pct = 24;
		snk_idle_pct = 74;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_tab[i])
			send_beat({dir_tab[i].az, dir_tab[i].ay, dir_tab[i].ax, dir_tab[i].ang},
				dir_tab[i].fixed);
		run_random(N_RANDOM / 3);
		src_idle_pct = 74;
		snk_idle_pct = 24;
		run_random(N_RANDOM / 3);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_off = 1'b1;
		run_random(N_RANDOM / 3);
		s_tvalid <= 1'b0;
		done_send = 1'b1;
	end

	// output side: random stall, plus one long hold-off with the input busy
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				m_tready <= 1'b0;
				repeat (200) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (matrix_q.size() == 0) begin
				$display("%t: unexpected beat %h user %b", $realtime, m_tdata, m_tuser);
				errors++;
			end else begin
				matrix_t e;
				e = matrix_q.pop_front();
				n_recv++;
				if (e.zero !== m_tuser) begin
					$display("%t: zero_axis exp %b got %b", $realtime, e.zero, m_tuser);
					errors++;
				end
				for (int k = 0; k < 9; k++)
					if (e.ent[16*k +: 16] !== m_tdata[16*k +: 16]) begin
						$display("%t: m%0d%0d exp %h got %h", $realtime, k / 3, k % 3,
							e.ent[16*k +: 16], m_tdata[16*k +: 16]);
						errors++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("watchdog expired, %0d matrices outstanding", matrix_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		wait (done_send);
		while (matrix_q.size() != 0) @(posedge clk);
		repeat (aar_pkg::PIPE_LAT + 10) @(posedge clk);
		$display("%0d beats in, %0d matrices checked, %0d with a zero axis",
			n_sent, n_recv, n_zero);
		$display("directed table plus random angles and axes under three throttle phases");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
